/* rtl/assert_macros.svh */
// Assertion macros shared by the Base64 stream encoder RTL.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define B64E_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define B64E_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define B64E_ASSERT(lbl, clk, rst_n, prop, msg)
`define B64E_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/b64e_pkg.sv */
// Shared types, constants and the alphabet function of the Base64 stream encoder.
// No dependencies; every RTL module imports this package.
package b64e_pkg;

	// Input transfer: one raw byte plus the end-of-stream flag.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	// Output transfer: one character plus the last-of-this-byte flag.
	typedef struct packed {
		logic [7:0] out_char;
		logic       run_end;
	} out_item_t;

	// One four-character block waiting to be serialized.
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] len;
		logic       newline;
	} blk_cmd_t;

	localparam logic [7:0] NEWLINE_CHAR = 8'd10;
	localparam logic [7:0] PAD_CHAR     = 8'd61;
	localparam logic [7:0] BPL_RESET    = 8'd18;

	// Group lengths.
	localparam logic [1:0] LEN_ONE   = 2'd1;
	localparam logic [1:0] LEN_TWO   = 2'd2;
	localparam logic [1:0] LEN_THREE = 2'd3;

	// Character positions within a block; the newline follows the last data slot.
	localparam logic [2:0] POS_LAST_DATA = 3'd3;
	localparam logic [2:0] POS_NEWLINE   = 3'd4;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// Maps a six-bit value onto the standard Base64 alphabet.
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		logic [7:0] c;
		w = {2'b00, v};
		if (v < 6'd26) begin
			c = 8'd65 + w;
		end else if (v < 6'd52) begin
			c = 8'd71 + w;
		end else if (v < 6'd62) begin
			c = w - 8'd4;
		end else if (v == 6'd62) begin
			c = 8'd43;
		end else begin
			c = 8'd47;
		end
		return c;
	endfunction

endpackage

/* rtl/base64_encode_stream.sv */
// Streaming Base64 encoder with line breaking: top level.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// Usage:
//   src_* carries one raw byte per transfer; final_byte marks the end of a stream.
//   dst_* carries one output character per transfer; run_end marks the last
//   character caused by an input byte. Both channels use valid/stall.
//   cfg_* writes blocks_per_line (four-character blocks per line, 0 = break after
//   every block); cfg_ready is always high. Write it only while the block is idle.
// Timing:
//   A byte that only joins a partial group is held in the front end. A byte that
//   closes a group passes through the block queue, the current-block register and
//   the output register before its first character appears, then one character per
//   cycle while dst_stall is low. The single output character register sets
//   throughput: 4 or 5 characters per three bytes. The block queue (QUEUE_DEPTH
//   blocks) lets the front keep taking bytes while characters drain.
// Reset clears the queue, any partial group and the line count, and sets
// blocks_per_line to 18. When dst_stall is high the output holds its character
// and the queue fills; once it is full, src_stall rises.
module base64_encode_stream #(
	parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  b64e_pkg::in_item_t  src_item,
	output logic                dst_valid,
	input  logic                dst_stall,
	output b64e_pkg::out_item_t dst_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);
	import b64e_pkg::*;

	logic     push;
	logic     full;
	logic     pop;
	logic     not_empty;
	blk_cmd_t push_cmd;
	blk_cmd_t pop_cmd;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	// Byte gathering and line accounting.
	b64e_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.push      (push),
		.cmd       (push_cmd),
		.full      (full)
	);

	// Decoupling queue of finished blocks.
	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.not_empty (not_empty)
	);

	// Character serializer.
	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (not_empty),
		.q_cmd     (pop_cmd),
		.q_pop     (pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_item  (dst_item)
	);

endmodule

/* rtl/b64e_front.sv */
// Front end of the Base64 stream encoder: gathers bytes into groups and decides line breaks.
// Depends on b64e_pkg.
module b64e_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  b64e_pkg::in_item_t  src_item,
	input  logic                cfg_valid,
	input  logic [7:0]          cfg_data,
	output logic                push,
	output b64e_pkg::blk_cmd_t  cmd,
	input  logic                full
);
	import b64e_pkg::*;

	logic [7:0] bpl_q;
	logic [1:0] cnt_q;
	logic [7:0] line_q;
	logic [7:0] held0_q;
	logic [7:0] held1_q;

	logic       acc;
	logic [1:0] len;
	logic       grp_done;
	logic [8:0] line_sum;
	logic       nl;

	// A byte transfer completes whenever the queue has room.
	assign src_stall = full;
	assign acc       = src_valid && !full;

	// Classify the byte: either it is held, or it closes a block.
	always_comb begin
		len      = cnt_q + 2'd1;
		grp_done = (len == LEN_THREE) || src_item.final_byte;
		line_sum = {1'b0, line_q} + 9'd1;
		nl       = (line_sum >= {1'b0, bpl_q}) || src_item.final_byte;
		push     = acc && grp_done;

		cmd.len     = len;
		cmd.newline = nl;
		cmd.b0      = (len == LEN_ONE) ? src_item.data_byte : held0_q;
		case (len)
			LEN_TWO: begin
				cmd.b1 = src_item.data_byte;
				cmd.b2 = 8'd0;
			end
			LEN_THREE: begin
				cmd.b1 = held1_q;
				cmd.b2 = src_item.data_byte;
			end
			default: begin
				cmd.b1 = 8'd0;
				cmd.b2 = 8'd0;
			end
		endcase
	end

	// Control state: line setting, group fill and blocks on the current line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpl_q  <= BPL_RESET;
			cnt_q  <= 2'd0;
			line_q <= 8'd0;
		end else begin
			if (cfg_valid) begin
				bpl_q <= cfg_data;
			end
			if (acc) begin
				if (grp_done) begin
					cnt_q  <= 2'd0;
					line_q <= nl ? 8'd0 : line_sum[7:0];
				end else begin
					cnt_q <= len;
				end
			end
		end
	end

	// Held bytes of a partial group.
	always_ff @(posedge clk) begin
		if (acc && !grp_done) begin
			if (cnt_q[0]) begin
				held1_q <= src_item.data_byte;
			end else begin
				held0_q <= src_item.data_byte;
			end
		end
	end

endmodule

/* rtl/b64e_queue.sv */
// Short block queue between the encoder front end and the character serializer.
// Depends on b64e_pkg and assert_macros.svh.
`include "assert_macros.svh"
module b64e_queue #(
	parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b64e_pkg::blk_cmd_t  push_cmd,
	output logic                full,
	input  logic                pop,
	output b64e_pkg::blk_cmd_t  pop_cmd,
	output logic                not_empty
);
	import b64e_pkg::*;

	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

	blk_cmd_t      mem_q [DEPTH];
	logic [IW-1:0] wr_q;
	logic [IW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_cmd   = mem_q[rd_q];

	// Storage for queued blocks.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_IDX) ? '0 : wr_q + IW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_IDX) ? '0 : rd_q + IW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`B64E_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full, "block queue overflow")
	`B64E_ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && !not_empty, "block queue underflow")
	`B64E_ASSERT(a_count_bound, clk, arst_n, cnt_q <= CW'(DEPTH), "block queue count out of range")

endmodule

/* rtl/b64e_back.sv */
// Back end of the Base64 stream encoder: turns queued blocks into one character per transfer.
// Depends on b64e_pkg and assert_macros.svh.
`include "assert_macros.svh"
module b64e_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  b64e_pkg::blk_cmd_t  q_cmd,
	output logic                q_pop,
	output logic                dst_valid,
	input  logic                dst_stall,
	output b64e_pkg::out_item_t dst_item
);
	import b64e_pkg::*;

	blk_cmd_t  cur_q;
	logic      cur_valid_q;
	logic [2:0] idx_q;
	logic      dst_valid_q;
	out_item_t dst_item_q;

	logic       adv;
	logic       is_last;
	logic [7:0] ch;

	assign dst_valid = dst_valid_q;
	assign dst_item  = dst_item_q;

	// Next character of the current block.
	always_comb begin
		case (idx_q)
			3'd0: ch = b64_char(cur_q.b0[7:2]);
			3'd1: ch = b64_char({cur_q.b0[1:0], cur_q.b1[7:4]});
			3'd2: ch = (cur_q.len != LEN_ONE) ? b64_char({cur_q.b1[3:0], cur_q.b2[7:6]})
			                                  : PAD_CHAR;
			3'd3: ch = (cur_q.len == LEN_THREE) ? b64_char(cur_q.b2[5:0]) : PAD_CHAR;
			default: ch = NEWLINE_CHAR;
		endcase
		is_last = (idx_q == (cur_q.newline ? POS_NEWLINE : POS_LAST_DATA));
		adv     = cur_valid_q && (!dst_valid_q || !dst_stall);
		q_pop   = q_valid && (!cur_valid_q || (adv && is_last));
	end

	// Block being serialized and its character position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 3'd0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 3'd0;
			end else if (adv) begin
				if (is_last) begin
					cur_valid_q <= 1'b0;
					idx_q       <= 3'd0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_cmd;
		end
	end

	// Output register: loaded when empty or when its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (adv) begin
			dst_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			dst_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dst_item_q.out_char <= ch;
			dst_item_q.run_end  <= is_last;
		end
	end

	`B64E_ASSERT(a_idx_range, clk, arst_n, idx_q <= POS_NEWLINE, "character position out of range")
	`B64E_ASSERT(a_nl_slot, clk, arst_n, !(cur_valid_q && idx_q == POS_NEWLINE) || cur_q.newline,
		"newline slot reached on a block without line break")
	`B64E_ASSERT(a_pop_when_free, clk, arst_n, !q_pop || !cur_valid_q || (adv && is_last),
		"block fetched while the current one is unfinished")

endmodule

/* tb/b64e_check_pkg.sv */
// Scoreboard for the Base64 stream encoder: predicts the character stream and checks it.
// Depends on b64e_pkg for the transfer types and the padding and newline characters.
package b64e_check_pkg;

	import b64e_pkg::*;

	class b64_line_scoreboard;

		string     alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
		bit [7:0]  line_limit;
		bit [7:0]  group_bytes [2];
		int        group_fill;
		int        line_blocks;
		out_item_t expected_chars [$];
		int        error_count;

		function new();
			line_limit     = BPL_RESET;
			group_bytes[0] = '0;
			group_bytes[1] = '0;
			group_fill     = 0;
			line_blocks    = 0;
			error_count    = 0;
		endfunction

		function void set_line_limit(bit [7:0] v);
			line_limit = v;
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction

		// Prints one line per mismatch and counts it.
		task report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			error_count++;
		endtask

		function bit [7:0] to_char(bit [5:0] v);
			return alphabet[v];
		endfunction

		function void push_char(bit [7:0] c, bit last);
			out_item_t r;
			r.out_char = c;
			r.run_end  = last;
			expected_chars.push_back(r);
		endfunction

		// Notes one accepted input transfer and queues the characters it causes.
		function void note_byte(in_item_t it);
			int       fill;
			bit [7:0] b0;
			bit [7:0] b1;
			bit [7:0] b2;
			bit       line_done;
			fill = group_fill + 1;

			// A byte that neither closes a group nor ends the stream is only held.
			if (fill < 3 && !it.final_byte) begin
				group_bytes[fill-1] = it.data_byte;
				group_fill          = fill;
				return;
			end

			// Short final groups are zero-filled.
			b0 = (fill == 1) ? it.data_byte : group_bytes[0];
			b1 = (fill == 2) ? it.data_byte : ((fill == 3) ? group_bytes[1] : 8'h00);
			b2 = (fill == 3) ? it.data_byte : 8'h00;

			// The line ends when it is full or the stream ends, with a single newline.
			line_done = (line_blocks + 1 >= line_limit) || it.final_byte;

			push_char(to_char(b0[7:2]), 1'b0);
			push_char(to_char({b0[1:0], b1[7:4]}), 1'b0);
			push_char((fill > 1) ? to_char({b1[3:0], b2[7:6]}) : PAD_CHAR, 1'b0);
			push_char((fill > 2) ? to_char(b2[5:0]) : PAD_CHAR, !line_done);
			if (line_done) begin
				push_char(NEWLINE_CHAR, 1'b1);
				line_blocks = 0;
			end else begin
				line_blocks = line_blocks + 1;
			end

			group_fill     = 0;
			group_bytes[0] = '0;
			group_bytes[1] = '0;
		endfunction

		// Compares one accepted output transfer with the oldest expected character.
		task check_char(out_item_t got);
			out_item_t want;
			if (expected_chars.size() == 0) begin
				report($sformatf("unexpected character %h run_end %b", got.out_char,
					got.run_end));
			end else begin
				want = expected_chars.pop_front();
				if (got.out_char !== want.out_char) begin
					report($sformatf("out_char %h, expected %h", got.out_char,
						want.out_char));
				end
				if (got.run_end !== want.run_end) begin
					report($sformatf("run_end %b, expected %b (char %h)", got.run_end,
						want.run_end, want.out_char));
				end
			end
		endtask

		// Characters still expected when the output has gone quiet are failures.
		task flush_leftover();
			if (expected_chars.size() != 0) begin
				report($sformatf("%0d expected characters never arrived",
					expected_chars.size()));
				expected_chars.delete();
			end
		endtask

	endclass

endpackage

/* tb/tb_top.sv */
// Top-level testbench of base64_encode_stream: directed and random byte streams
// under several line lengths and idling patterns. Depends on b64e_pkg and b64e_check_pkg.
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import b64e_pkg::*;
	import b64e_check_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int SUB_ITEMS    = 35;
	localparam int PAUSE_AT     = 150;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       src_valid = 1'b0;
	logic       src_stall;
	in_item_t   src_item  = '0;
	logic       dst_valid;
	logic       dst_stall = 1'b0;
	out_item_t  dst_item;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data  = '0;

	int src_idle_pct  = 0;
	int dst_stall_pct = 0;

	b64_line_scoreboard sb;

	always #5 clk = ~clk;

	base64_encode_stream dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_item  (dst_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Output side: check each character transfer and pick the next stall.
	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			sb.check_char(dst_item);
		end
		dst_stall <= (dst_stall_pct != 0) && ($urandom_range(99) < dst_stall_pct);
	end

	// Offers one byte, idling first at random, and notes it once the transfer happens.
	task send_byte(input logic [7:0] b, input logic fin);
		in_item_t it;
		it.data_byte  = b;
		it.final_byte = fin;
		while ((src_idle_pct != 0) && ($urandom_range(99) < src_idle_pct)) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= it;
		@(posedge clk);
		while (src_stall) begin
			@(posedge clk);
		end
		sb.note_byte(it);
	endtask

	// Holds the input until every expected character has come, then lets the pipe settle.
	task wait_idle();
		int guard;
		guard = 0;
		src_valid <= 1'b0;
		while (sb.pending() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.flush_leftover();
	endtask

	task write_line_limit(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		sb.set_line_limit(v);
	endtask

	// Stimulus: directed streams first, then random streams in four idling phases.
	initial begin
		int left;
		int total;
		int count;
		left  = 0;
		total = 0;
		sb    = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short final groups pad with two and one '='; a full group has none.
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h3f, 1'b0);
		send_byte(8'hc0, 1'b1);

		// Two blocks on the line, then the limit drops below that count.
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h04, 1'b0);
		send_byte(8'h05, 1'b0);
		send_byte(8'h06, 1'b0);
		wait_idle();
		write_line_limit(8'd1);
		send_byte(8'h07, 1'b1);

		// A zero limit breaks after every block.
		wait_idle();
		write_line_limit(8'd0);
		send_byte(8'haa, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h0f, 1'b0);
		send_byte(8'hf0, 1'b1);

		// The line fills on the final block: only one newline.
		wait_idle();
		write_line_limit(8'd1);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b1);
		wait_idle();
		write_line_limit(8'd255);
		send_byte(8'h80, 1'b1);

		// Random part: mostly whole streams, some stray bytes that may end a stream early.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
				1: begin src_idle_pct = 50; dst_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  dst_stall_pct = 50; end
				default: begin src_idle_pct = 34; dst_stall_pct = 34; end
			endcase
			for (int sub = 0; sub < 3; sub++) begin
				wait_idle();
				case ($urandom_range(5))
					0: write_line_limit(8'd0);
					1: write_line_limit(8'd1);
					2: write_line_limit(8'd255);
					3: write_line_limit(8'd2);
					default: write_line_limit(8'($urandom_range(255)));
				endcase
				count = 0;
				while (count < SUB_ITEMS) begin
					if ($urandom_range(4) == 0) begin
						send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
					end else begin
						if (left == 0) begin
							left = ($urandom_range(3) == 0) ? $urandom_range(60, 25)
								: $urandom_range(12, 1);
						end
						left--;
						send_byte(8'($urandom_range(255)), left == 0);
					end
					count++;
					total++;
					// The sender stops mid-stream until the output has caught up.
					if (total == PAUSE_AT) begin
						wait_idle();
					end
				end
			end
		end

		wait_idle();
		if (sb.error_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_encode_stream.sv
tb/b64e_check_pkg.sv
tb/tb_top.sv
